### src/nsc_pkg.sv
`timescale 1ns / 1ps

package nsc_pkg;

  // framing characters
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;

  // five-byte talker and type patterns, newest byte in the low bits
  localparam logic [39:0] WinGga = 40'h47_50_47_47_41;
  localparam logic [39:0] WinRmc = 40'h47_50_52_4D_43;

  // sentence classification codes
  typedef enum logic [1:0] {
    KindGga     = 2'd0,
    KindRmc     = 2'd1,
    KindUnknown = 2'd2,
    KindCsumErr = 2'd3
  } kind_e;

  // one result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } res_t;

  // hex digit decode: is_hex flag and nibble value
  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

### src/nsc_if.sv
`timescale 1ns / 1ps

// received byte channel
interface nsc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// sentence result channel
interface nsc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_kind;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (output valid, output sentence_kind, output computed_sum,
                  output received_sum, input ready);
  modport sink (input valid, input sentence_kind, input computed_sum,
                input received_sum, output ready);
endinterface

### src/nmea_sentence_checker.sv
`timescale 1ns / 1ps
// path: an accepted byte is registered into the tracker stage; a closing carriage
//   return then loads its result word into the result register
// throughput: one byte per cycle; the tracker stage stalls only when it holds
//   a closing byte and the result register is full and not being taken
// reset: asynchronous, active low; clears all tracking state and valid flags

module nmea_sentence_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  nsc_rx_if.sink            rx_i,
  nsc_res_if.source         res_o
);

  logic          s1_valid_q, s1_valid_d;
  logic [7:0]    s1_byte_q;
  logic          advance;
  logic          emit;
  nsc_pkg::res_t res_now;
  logic          out_valid_q, out_valid_d;
  nsc_pkg::res_t out_q;

  // tracker stage moves unless its result word has nowhere to go
  assign advance    = s1_valid_q && (!emit || !out_valid_q || res_o.ready);
  assign rx_i.ready = !s1_valid_q || advance;

  nsc_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .byte_i (s1_byte_q),
    .emit_o (emit),
    .res_o  (res_now)
  );

  // input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res_now;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.sentence_kind = out_q.kind;
  assign res_o.computed_sum  = out_q.computed_sum;
  assign res_o.received_sum  = out_q.received_sum;

  // the stage stalls only on a closing byte against a blocked result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |-> (emit && out_valid_q && !res_o.ready))
    else $error("tracker stage stalled without cause");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |-> (!out_valid_q || res_o.ready))
    else $error("result word overwritten");

  // a word fills the result register only from a closing byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(advance && emit))
    else $error("result register state inconsistent");

endmodule

### src/nsc_tracker.sv
`timescale 1ns / 1ps

module nsc_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [7:0]    byte_i,
  output logic          emit_o,
  output nsc_pkg::res_t res_o
);

  logic        in_sentence_q, in_sentence_d;
  logic        star_seen_q, star_seen_d;
  logic        hex_done_q, hex_done_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  parsed_q, parsed_d;
  logic [39:0] win_q, win_d;
  logic        gga_q, gga_d;
  logic        rmc_q, rmc_d;
  nsc_pkg::hex_t hex;

  assign hex = nsc_pkg::hex_decode(byte_i);

  // a carriage return closes an open sentence with one result word
  assign emit_o = in_sentence_q && (byte_i == nsc_pkg::ChCr);

  // classification of the closing sentence
  always_comb begin
    if (!star_seen_q || (xor_q != parsed_q)) begin
      res_o.kind = nsc_pkg::KindCsumErr;
    end else if (gga_q) begin
      res_o.kind = nsc_pkg::KindGga;
    end else if (rmc_q) begin
      res_o.kind = nsc_pkg::KindRmc;
    end else begin
      res_o.kind = nsc_pkg::KindUnknown;
    end
    res_o.computed_sum = xor_q;
    res_o.received_sum = parsed_q;
  end

  // per-byte tracking update
  always_comb begin
    in_sentence_d = in_sentence_q;
    star_seen_d   = star_seen_q;
    hex_done_d    = hex_done_q;
    xor_d         = xor_q;
    parsed_d      = parsed_q;
    win_d         = win_q;
    gga_d         = gga_q;
    rmc_d         = rmc_q;
    if (en_i) begin
      if (byte_i == nsc_pkg::ChDollar) begin
        in_sentence_d = 1'b1;
        star_seen_d   = 1'b0;
        hex_done_d    = 1'b0;
        xor_d         = 8'd0;
        parsed_d      = 8'd0;
        win_d         = 40'd0;
        gga_d         = 1'b0;
        rmc_d         = 1'b0;
      end else if (emit_o) begin
        in_sentence_d = 1'b0;
      end else if (in_sentence_q) begin
        if (!star_seen_q) begin
          if (byte_i == nsc_pkg::ChStar) begin
            star_seen_d = 1'b1;
          end else begin
            xor_d = xor_q ^ byte_i;
          end
        end else if (!hex_done_q) begin
          if (hex.is_hex) begin
            parsed_d = {parsed_q[3:0], hex.value};
          end else begin
            hex_done_d = 1'b1;
          end
        end
        win_d = {win_q[31:0], byte_i};
        if (win_d == nsc_pkg::WinGga) gga_d = 1'b1;
        if (win_d == nsc_pkg::WinRmc) rmc_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sentence_q <= 1'b0;
      star_seen_q   <= 1'b0;
      hex_done_q    <= 1'b0;
      xor_q         <= 8'd0;
      parsed_q      <= 8'd0;
      win_q         <= 40'd0;
      gga_q         <= 1'b0;
      rmc_q         <= 1'b0;
    end else begin
      in_sentence_q <= in_sentence_d;
      star_seen_q   <= star_seen_d;
      hex_done_q    <= hex_done_d;
      xor_q         <= xor_d;
      parsed_q      <= parsed_d;
      win_q         <= win_d;
      gga_q         <= gga_d;
      rmc_q         <= rmc_d;
    end
  end

  // a dollar always restarts with clean tracking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && byte_i == nsc_pkg::ChDollar) |=>
      (in_sentence_q && !star_seen_q && xor_q == 8'd0 && parsed_q == 8'd0))
    else $error("dollar did not restart tracking");

  // hex parsing only ends after a star
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_done_q |-> star_seen_q)
    else $error("hex parsing ended without a star");

  // the checksum only moves while the star is unseen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (star_seen_q && !(en_i && byte_i == nsc_pkg::ChDollar)) |=> $stable(xor_q))
    else $error("running sum changed after star");

endmodule
